>>> hdl/mcot_pkg.sv
`timescale 1ns / 1ps
// Types and codes shared by the multi-channel one-shot timer.
// No dependencies.
package mcot_pkg;

  localparam logic [2:0] OP_SET        = 3'd0;
  localparam logic [2:0] OP_CANCEL     = 3'd1;
  localparam logic [2:0] OP_CANCEL_ALL = 3'd2;
  localparam logic [2:0] OP_QUERY      = 3'd3;
  localparam logic [2:0] OP_TICK       = 3'd4;

  localparam logic [1:0] KIND_OK     = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_EXPIRY = 2'd3;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  channel;
    logic [31:0] duration_ms;
  } mcot_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  event_channel;
    logic [31:0] remaining_ms;
    logic        timer_present;
    logic [4:0]  active_count;
    logic        last;
  } mcot_out_t;

endpackage

>>> hdl/multi_channel_oneshot_timer_top.sv
`timescale 1ns / 1ps
// Multi-channel one-shot millisecond timer: command sequencer, remaining-time RAM,
// running flags and result register. Depends on mcot_pkg.
//
//   channel | ports                         | beat
//   --------+-------------------------------+-----------------------------
//   in      | in_valid, in_ready, in_data   | one command (mcot_in_t)
//   out     | out_valid, out_ready, out_data| one result (mcot_out_t)
//   cfg     | cfg_valid, cfg_ready, cfg_data| switch_count write
//
// Set, cancel, cancel-all and unused ops load a result from idle; query waits in
// ST_QRY for the registered RAM read. A tick walks the RAM (read in ST_RD, write
// in ST_UPD per channel), then scans the expiry mask in ST_EMIT to issue results.
// Reset clears running flags and the active count at once; no clearing pass.
// A stalled result register holds the sequencer; cfg_ready is always high.
module multi_channel_oneshot_timer_top
  import mcot_pkg::*;
#(
  parameter int MAX_CHANNELS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  mcot_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output mcot_out_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [4:0] cfg_data
);

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CHANNELS - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_QRY  = 5'b00010,
    ST_RD   = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [MAX_CHANNELS-1:0] running_r, running_nxt;
  logic [MAX_CHANNELS-1:0] exp_mask_r, exp_mask_nxt;
  logic [CNT_W-1:0]        act_r, act_nxt;
  logic [CNT_W-1:0]        exp_left_r, exp_left_nxt;
  logic [4:0]              sc_r;
  logic [7:0]              qchan_r, qchan_nxt;
  logic                    qpres_r, qpres_nxt;
  logic                    out_valid_r;
  mcot_out_t               out_r;

  logic [31:0]      rem_mem [MAX_CHANNELS];
  logic [31:0]      rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [31:0]      mem_wd;
  logic [IDX_W-1:0] mem_ra;

  logic             slot_free;
  logic             load;
  mcot_out_t        ld_data;
  logic             in_table;
  logic [IDX_W-1:0] in_idx;
  logic             accept;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;
  assign in_table  = 9'(in_data.channel) < 9'(MAX_CHANNELS);
  assign in_idx    = in_table ? in_data.channel[IDX_W-1:0] : '0;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    running_nxt  = running_r;
    exp_mask_nxt = exp_mask_r;
    act_nxt      = act_r;
    exp_left_nxt = exp_left_r;
    qchan_nxt    = qchan_r;
    qpres_nxt    = qpres_r;
    mem_we       = 1'b0;
    mem_wa       = idx_r;
    mem_wd       = rd_data_r - 32'd1;
    mem_ra       = in_idx;
    load         = 1'b0;
    ld_data      = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ld_data.event_channel = in_data.channel;
          ld_data.last          = 1'b1;
          case (in_data.op)
            OP_SET: begin
              load = 1'b1;
              if (in_table && (in_data.channel < {3'b000, sc_r}) &&
                  (in_data.duration_ms != 32'd0)) begin
                mem_we              = 1'b1;
                mem_wa              = in_idx;
                mem_wd              = in_data.duration_ms;
                running_nxt[in_idx] = 1'b1;
                if (!running_r[in_idx]) begin
                  act_nxt = act_r + CNT_W'(1);
                end
                ld_data.kind = KIND_OK;
              end else begin
                ld_data.kind = KIND_REJECT;
              end
              ld_data.active_count = 5'(act_nxt);
            end
            OP_CANCEL: begin
              load = 1'b1;
              if (in_table && running_r[in_idx]) begin
                running_nxt[in_idx] = 1'b0;
                act_nxt             = act_r - CNT_W'(1);
              end
              ld_data.kind         = KIND_OK;
              ld_data.active_count = 5'(act_nxt);
            end
            OP_CANCEL_ALL: begin
              load                  = 1'b1;
              running_nxt           = '0;
              act_nxt               = '0;
              ld_data.kind          = KIND_OK;
              ld_data.event_channel = 8'd0;
            end
            OP_QUERY: begin
              qchan_nxt = in_data.channel;
              qpres_nxt = in_table && running_r[in_idx];
              state_nxt = ST_QRY;
            end
            OP_TICK: begin
              idx_nxt      = '0;
              exp_mask_nxt = '0;
              exp_left_nxt = '0;
              state_nxt    = ST_RD;
            end
            default: begin
              load                 = 1'b1;
              ld_data.kind         = KIND_REJECT;
              ld_data.active_count = 5'(act_r);
            end
          endcase
        end
      end
      ST_QRY: begin
        load                  = 1'b1;
        ld_data.kind          = KIND_QUERY;
        ld_data.event_channel = qchan_r;
        ld_data.remaining_ms  = qpres_r ? rd_data_r : 32'd0;
        ld_data.timer_present = qpres_r;
        ld_data.active_count  = 5'(act_r);
        ld_data.last          = 1'b1;
        state_nxt             = ST_IDLE;
      end
      ST_RD: begin
        mem_ra    = idx_r;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (running_r[idx_r]) begin
          if (rd_data_r <= 32'd1) begin
            running_nxt[idx_r]  = 1'b0;
            exp_mask_nxt[idx_r] = 1'b1;
            act_nxt             = act_r - CNT_W'(1);
            exp_left_nxt        = exp_left_r + CNT_W'(1);
          end else begin
            mem_we = 1'b1;
          end
        end
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_RD;
        end
      end
      ST_EMIT: begin
        ld_data.active_count = 5'(act_r);
        if (exp_left_r == '0) begin
          if (slot_free) begin
            load         = 1'b1;
            ld_data.kind = KIND_OK;
            ld_data.last = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else if (exp_mask_r[idx_r]) begin
          if (slot_free) begin
            load                  = 1'b1;
            ld_data.kind          = KIND_EXPIRY;
            ld_data.event_channel = 8'(idx_r);
            ld_data.last          = (exp_left_r == CNT_W'(1));
            exp_mask_nxt[idx_r]   = 1'b0;
            exp_left_nxt          = exp_left_r - CNT_W'(1);
            if (exp_left_r == CNT_W'(1)) begin
              idx_nxt   = '0;
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
            end
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rem_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= rem_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      running_r   <= '0;
      exp_mask_r  <= '0;
      act_r       <= '0;
      exp_left_r  <= '0;
      sc_r        <= 5'd16;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      running_r  <= running_nxt;
      exp_mask_r <= exp_mask_nxt;
      act_r      <= act_nxt;
      exp_left_r <= exp_left_nxt;
      if (cfg_valid && cfg_ready) begin
        sc_r <= cfg_data;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    qchan_r <= qchan_nxt;
    qpres_r <= qpres_nxt;
    if (load) begin
      out_r <= ld_data;
    end
  end

endmodule
